// ===== sv/dha_pkg.sv =====
`default_nettype none

package dha_pkg;

  // sample width, fixed by the payload structs
  localparam int SAMPLE_BITS = 16;
  // default width of the elapsed-tick counters and of delay_ticks
  localparam int COUNT_BITS_DEF = 16;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 2;
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SETPOINT   = 2'd0,
    CFG_HYSTERESIS = 2'd1,
    CFG_DELAY      = 2'd2
  } cfg_index_t;

  // item operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // input item
  typedef struct packed {
    logic                          op;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  // result item
  typedef struct packed {
    logic alarm_active;
    logic changed;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/dha_cfg_regs.sv =====
`default_nettype none

module dha_cfg_regs
  import dha_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int CFG_W      = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire cfg_index_t                    cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_wdata,
  output logic signed [SAMPLE_BITS-1:0]      setpoint,
  output logic        [SAMPLE_BITS-2:0]      hysteresis,
  output logic        [COUNT_BITS-1:0]       delay_ticks
);

  logic signed [SAMPLE_BITS-1:0] setpoint_r;
  logic        [SAMPLE_BITS-2:0] hysteresis_r;
  logic        [COUNT_BITS-1:0]  delay_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r   <= '0;
      hysteresis_r <= '0;
      delay_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETPOINT:   setpoint_r   <= $signed(cfg_wdata[SAMPLE_BITS-1:0]);
        CFG_HYSTERESIS: hysteresis_r <= cfg_wdata[SAMPLE_BITS-2:0];
        CFG_DELAY:      delay_r      <= cfg_wdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign setpoint    = setpoint_r;
  assign hysteresis  = hysteresis_r;
  assign delay_ticks = delay_r;

endmodule

`default_nettype wire

// ===== sv/dha_eval.sv =====
`default_nettype none

module dha_eval
  import dha_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire in_item_t                      item,
  input  wire logic signed [SAMPLE_BITS-1:0] setpoint,
  input  wire logic        [SAMPLE_BITS-2:0] hysteresis,
  input  wire logic        [COUNT_BITS-1:0]  delay_ticks,
  output out_item_t                          result
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic                  flag_r, flag_nxt;
  logic                  high_run_r, high_run_nxt;
  logic                  low_run_r, low_run_nxt;
  logic [COUNT_BITS-1:0] high_cnt_r, high_cnt_nxt;
  logic [COUNT_BITS-1:0] low_cnt_r, low_cnt_nxt;

  logic signed [SAMPLE_BITS:0] release_lvl;
  logic signed [SAMPLE_BITS:0] sample_x;
  logic                        is_high;
  logic                        is_low;

  // release level one bit wider so it never wraps
  assign release_lvl = {setpoint[SAMPLE_BITS-1], setpoint}
                     - $signed({2'b00, hysteresis});
  assign sample_x    = {item.sample[SAMPLE_BITS-1], item.sample};
  assign is_high     = item.sample >= setpoint;
  assign is_low      = sample_x < release_lvl;

  // run tracking, then the flag decision
  always_comb begin
    high_run_nxt = high_run_r;
    low_run_nxt  = low_run_r;
    high_cnt_nxt = high_cnt_r;
    low_cnt_nxt  = low_cnt_r;
    flag_nxt     = flag_r;
    if (item.op == OP_SAMPLE) begin
      if (is_high) begin
        if (!high_run_r) begin
          high_cnt_nxt = '0;
        end
        high_run_nxt = 1'b1;
      end else begin
        high_run_nxt = 1'b0;
      end
      if (is_low) begin
        if (!low_run_r) begin
          low_cnt_nxt = '0;
        end
        low_run_nxt = 1'b1;
      end else begin
        low_run_nxt = 1'b0;
      end
    end else begin
      if (high_run_r && high_cnt_r != CNT_MAX) begin
        high_cnt_nxt = high_cnt_r + 1'b1;
      end
      if (low_run_r && low_cnt_r != CNT_MAX) begin
        low_cnt_nxt = low_cnt_r + 1'b1;
      end
    end
    // a flag change ends the opposite run
    if (!flag_r && high_run_nxt && high_cnt_nxt >= delay_ticks) begin
      flag_nxt    = 1'b1;
      low_run_nxt = 1'b0;
    end else if (flag_r && low_run_nxt && low_cnt_nxt >= delay_ticks) begin
      flag_nxt     = 1'b0;
      high_run_nxt = 1'b0;
    end
  end

  // state commits when the item moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r     <= 1'b0;
      high_run_r <= 1'b0;
      low_run_r  <= 1'b0;
      high_cnt_r <= '0;
      low_cnt_r  <= '0;
    end else if (advance) begin
      flag_r     <= flag_nxt;
      high_run_r <= high_run_nxt;
      low_run_r  <= low_run_nxt;
      high_cnt_r <= high_cnt_nxt;
      low_cnt_r  <= low_cnt_nxt;
    end
  end

  assign result.alarm_active = flag_nxt;
  assign result.changed      = flag_nxt ^ flag_r;

endmodule

`default_nettype wire

// ===== sv/delayed_hysteresis_alarm_unit.sv =====
`default_nettype none

// Alarm flag with setpoint, hysteresis and time delay. Each input item is
// either a sample (op 0) or one elapsed tick (op 1); each item gives one
// result with the flag after it and a strobe that says whether it changed.
// An item passes an input register and then a result register, from which
// its result is presented; one item is taken every cycle while the result
// side keeps up.
// Configuration writes are single-cycle and should be made while no item is
// in flight.

module delayed_hysteresis_alarm_unit
  import dha_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int CFG_W      = (SAMPLE_BITS > COUNT_BITS) ? SAMPLE_BITS : COUNT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_item,
  input  wire logic             cfg_we,
  input  wire cfg_index_t       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  logic signed [SAMPLE_BITS-1:0] setpoint;
  logic        [SAMPLE_BITS-2:0] hysteresis;
  logic        [COUNT_BITS-1:0]  delay_ticks;

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t result;
  logic      advance;
  logic      in_take;

  dha_cfg_regs #(
    .COUNT_BITS (COUNT_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .setpoint    (setpoint),
    .hysteresis  (hysteresis),
    .delay_ticks (delay_ticks)
  );

  // held item moves on when the result register is free or being drained
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  dha_eval #(
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (advance),
    .item        (in_item_r),
    .setpoint    (setpoint),
    .hysteresis  (hysteresis),
    .delay_ticks (delay_ticks),
    .result      (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

// ===== test/tb_delayed_hysteresis_alarm_unit.sv =====
module tb_delayed_hysteresis_alarm_unit;
  import dha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_W   = COUNT_BITS_DEF;
  localparam int CFG_W     = (SAMPLE_BITS > COUNT_W) ? SAMPLE_BITS : COUNT_W;
  localparam int CNT_MAX   = (1 << COUNT_W) - 1;
  localparam int MAX_CYCLES = 1000000;
  localparam int SMAX      = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SMIN      = -(1 << (SAMPLE_BITS - 1));

  // register index with no register behind it
  localparam cfg_index_t CFG_SPARE = cfg_index_t'(2'd3);

  typedef enum int {ZONE_HIGH, ZONE_LOW, ZONE_DEAD, ZONE_ANY} zone_t;

  // flag predictor and queue of flags still to come
  class alarm_scoreboard;
    int setpoint_v;
    int hyst_v;
    int delay_v;
    bit flag;
    bit high_run;
    bit low_run;
    int high_cnt;
    int low_cnt;
    out_item_t due_flags[$];
    int errors;
    int checked;
    int flips;
    int n_samples;
    int n_ticks;
    int settings;

    function new();
      setpoint_v = 0;
      hyst_v     = 0;
      delay_v    = 0;
      flag       = 1'b0;
      high_run   = 1'b0;
      low_run    = 1'b0;
      high_cnt   = 0;
      low_cnt    = 0;
      errors     = 0;
      checked    = 0;
      flips      = 0;
      n_samples  = 0;
      n_ticks    = 0;
      settings   = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_W-1:0] v);
      case (idx)
        CFG_SETPOINT:   setpoint_v = $signed(v[SAMPLE_BITS-1:0]);
        CFG_HYSTERESIS: hyst_v     = int'(v[SAMPLE_BITS-2:0]);
        CFG_DELAY:      delay_v    = int'(v[COUNT_W-1:0]);
        default: ;
      endcase
    endfunction

    // work out the flag after an accepted item
    function void note_item(in_item_t it);
      bit was;
      int s;
      int rel;
      out_item_t want;
      was = flag;
      if (it.op == OP_SAMPLE) begin
        n_samples++;
        s   = $signed(it.sample);
        rel = setpoint_v - hyst_v;
        if (s >= setpoint_v) begin
          if (!high_run) begin
            high_run = 1'b1;
            high_cnt = 0;
          end
        end else begin
          high_run = 1'b0;
        end
        if (s < rel) begin
          if (!low_run) begin
            low_run = 1'b1;
            low_cnt = 0;
          end
        end else begin
          low_run = 1'b0;
        end
      end else begin
        n_ticks++;
        if (high_run && high_cnt < CNT_MAX) high_cnt++;
        if (low_run && low_cnt < CNT_MAX) low_cnt++;
      end
      // a run that has lasted long enough switches the flag and ends the other run
      if (!flag && high_run && high_cnt >= delay_v) begin
        flag    = 1'b1;
        low_run = 1'b0;
      end else if (flag && low_run && low_cnt >= delay_v) begin
        flag     = 1'b0;
        high_run = 1'b0;
      end
      want.alarm_active = flag;
      want.changed      = (flag != was);
      due_flags.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (got.changed) flips++;
      if (due_flags.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: active=%0d changed=%0d",
                   got.alarm_active, got.changed);
        return;
      end
      want = due_flags.pop_front();
      if (got.alarm_active !== want.alarm_active || got.changed !== want.changed) begin
        errors++;
        if (errors <= 10)
          $display("mismatch on result %0d: want active=%0d changed=%0d, %s%0d changed=%0d",
                   checked, want.alarm_active, want.changed, "got active=",
                   got.alarm_active, got.changed);
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_item;
  logic             cfg_we;
  cfg_index_t       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  alarm_scoreboard sb = new();
  bit calm;
  int stall_left;
  int cycles;

  delayed_hysteresis_alarm_unit #(
    .COUNT_BITS(COUNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result side: check each accepted result, then stall for a random spell
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_item);
        stall_left = calm ? 0 : $urandom_range(0, 6);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // offer one item after a random gap and hold it until taken
  task automatic send_item(in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(it);
  endtask

  task automatic send_sample(int v);
    in_item_t it;
    it.op     = OP_SAMPLE;
    it.sample = v[SAMPLE_BITS-1:0];
    send_item(it);
  endtask

  // the sample field of a tick carries noise
  task automatic send_tick();
    in_item_t it;
    it.op     = OP_TICK;
    it.sample = SAMPLE_BITS'($urandom);
    send_item(it);
  endtask

  // wait for every result in flight, with a bound
  task automatic drain();
    int n;
    n = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.due_flags.size() != 0 && n < 2000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // write all registers, plus one write to the unused index
  task automatic set_config(logic [CFG_W-1:0] sp, logic [CFG_W-1:0] hy,
                            logic [CFG_W-1:0] dl);
    cfg_index_t       idx[4];
    logic [CFG_W-1:0] val[4];
    int k;
    idx = '{CFG_SETPOINT, CFG_HYSTERESIS, CFG_DELAY, CFG_SPARE};
    val = '{sp, hy, dl, CFG_W'($urandom)};
    for (k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
    sb.settings++;
  endtask

  // a sample in the chosen zone around the thresholds
  function automatic int pick_sample(zone_t zone);
    int lo;
    int hi;
    int rel;
    rel = sb.setpoint_v - sb.hyst_v;
    case (zone)
      ZONE_HIGH: begin
        lo = sb.setpoint_v;
        hi = ($urandom_range(0, 3) == 0) ? SMAX : sb.setpoint_v + 3;
      end
      ZONE_LOW: begin
        hi = rel - 1;
        lo = ($urandom_range(0, 3) == 0) ? SMIN : rel - 4;
      end
      ZONE_DEAD: begin
        lo = rel;
        hi = sb.setpoint_v - 1;
      end
      default: begin
        lo = SMIN;
        hi = SMAX;
      end
    endcase
    if (lo < SMIN) lo = SMIN;
    if (lo > SMAX) lo = SMAX;
    if (hi < SMIN) hi = SMIN;
    if (hi > SMAX) hi = SMAX;
    if (hi < lo) hi = lo;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly runs of ticks after a sample in a chosen zone, with some noise
  task automatic run_random_phase(int n_items);
    int done;
    int r;
    int lim;
    int n_tk;
    int k;
    zone_t zone;
    in_item_t it;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      if ($urandom_range(0, 9) == 0) begin
        it.op     = 1'($urandom_range(0, 1));
        it.sample = SAMPLE_BITS'($urandom);
        send_item(it);
        done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40)      zone = ZONE_HIGH;
        else if (r < 80) zone = ZONE_LOW;
        else if (r < 95) zone = ZONE_DEAD;
        else             zone = ZONE_ANY;
        send_sample(pick_sample(zone));
        done++;
        lim  = (sb.delay_v < 10) ? sb.delay_v + 2 : 12;
        n_tk = $urandom_range(0, lim);
        for (k = 0; k < n_tk; k++) begin
          send_tick();
          done++;
        end
      end
    end
  endtask

  // stimulus
  initial begin
    int ph;
    int k;
    logic [CFG_W-1:0] sp;
    logic [CFG_W-1:0] hy;
    logic [CFG_W-1:0] dl;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SETPOINT;
    cfg_wdata = '0;
    calm      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: ticks before any sample, then the range ends
    send_tick();
    send_tick();
    send_sample(0);
    send_sample(-1);
    send_sample(SMAX);
    send_sample(SMIN);
    send_tick();
    drain();

    // release threshold below the sample range, so no low run
    set_config(16'h8000, 16'h7fff, 16'h0000);
    send_sample(SMIN);
    send_sample(5);
    send_tick();
    drain();

    // top setpoint, masked hysteresis bit, short delay
    set_config(16'h7fff, 16'hffff, 16'd3);
    send_sample(SMAX - 1);
    send_sample(-1);
    for (k = 0; k < 3; k++) send_tick();
    send_sample(SMAX);
    send_tick();
    // leaving the condition ends the run
    send_sample(100);
    for (k = 0; k < 3; k++) send_tick();
    send_sample(SMAX);
    for (k = 0; k < 3; k++) send_tick();
    drain();

    // random settings, extremes among them
    for (ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0:       sp = 16'h8000;
        1:       sp = 16'h7fff;
        2:       sp = CFG_W'($urandom);
        default: sp = CFG_W'(int'($urandom_range(0, 400)) - 200);
      endcase
      case ($urandom_range(0, 3))
        0:       hy = 16'h0000;
        1:       hy = 16'h7fff;
        2:       hy = CFG_W'($urandom);
        default: hy = {1'($urandom_range(0, 1)), 15'($urandom_range(0, 50))};
      endcase
      case ($urandom_range(0, 7))
        0, 1:    dl = 16'h0000;
        2:       dl = 16'h0001;
        3:       dl = 16'hffff;
        default: dl = CFG_W'($urandom_range(2, 6));
      endcase
      set_config(sp, hy, dl);
      run_random_phase(200);
      drain();
    end

    // longest delay: a long high run stays short of it and the flag holds
    calm = 1'b0;
    set_config(16'h0000, 16'h0000, 16'h0000);
    send_sample(SMIN);
    drain();
    set_config(16'h0000, 16'h0000, 16'hffff);
    calm = 1'b1;
    send_sample(0);
    for (k = 0; k < 40; k++) send_tick();
    send_sample(-5);
    for (k = 0; k < 10; k++) send_tick();
    drain();
    calm = 1'b0;

    if (sb.due_flags.size() != 0) begin
      $display("%0d results never arrived", sb.due_flags.size());
      sb.errors += sb.due_flags.size();
    end
    $display("covered %0d samples and %0d ticks over %0d register settings",
             sb.n_samples, sb.n_ticks, sb.settings);
    $display("%0d results checked, %0d flag changes, %0d errors",
             sb.checked, sb.flips, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
